### hw/rtl/esc_pkg.sv
`default_nettype none

package esc_pkg;

	// Field widths
	localparam int SECS_W  = 32;
	localparam int ZONE_W  = 5;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int MDAY_W  = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 12;

	// Local time after the zone offset, clamped at zero, fits 33 bits
	localparam int T_W    = 33;
	localparam int DIFF_W = T_W + 1;

	localparam int SECS_IN_MIN  = 60;
	localparam int SECS_IN_HOUR = 3600;
	localparam int SECS_IN_DAY  = 86400;

	// Subtrahends of the shared unit, in seconds
	localparam logic [T_W-1:0] MIN_SECS         = T_W'(SECS_IN_MIN);
	localparam logic [T_W-1:0] HOUR_SECS        = T_W'(SECS_IN_HOUR);
	localparam logic [T_W-1:0] DAY_SECS         = T_W'(SECS_IN_DAY);
	localparam logic [T_W-1:0] LEAP_YEAR_SECS   = T_W'(366 * SECS_IN_DAY);
	localparam logic [T_W-1:0] COMMON_YEAR_SECS = T_W'(365 * SECS_IN_DAY);

	localparam logic [3:0]        DAYS_PER_WEEK    = 4'd7;
	localparam logic [WDAY_W-1:0] WEEKDAY_OF_EPOCH = 3'd3;

	localparam logic signed [16:0] SECS_PER_HOUR = 17'sd3600;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR  = YEAR_W'(1970);
	localparam logic [1:0]        EPOCH_MOD4  = 2'd2;
	localparam logic [6:0]        EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]        EPOCH_MOD400 = 9'd370;

	localparam logic [ZONE_W-1:0] ZONE_RESET = ZONE_W'(1);
	localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = MONTH_W'(11);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_YEAR = 6'b000010,
		S_MON  = 6'b000100,
		S_DAY  = 6'b001000,
		S_HR   = 6'b010000,
		S_MIN  = 6'b100000
	} esc_state_t;

	// Month length, month index counted from zero
	function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
		input logic leap);
		logic [MDAY_W-1:0] len;
		begin
			case (mon)
				4'd1: len = leap ? 5'd29 : 5'd28;
				4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

	// Month length in seconds, month index counted from zero
	function automatic logic [T_W-1:0] month_secs(input logic [MONTH_W-1:0] mon,
		input logic leap);
		logic [T_W-1:0] secs;
		begin
			case (mon)
				4'd1: secs = leap ? T_W'(29 * SECS_IN_DAY) : T_W'(28 * SECS_IN_DAY);
				4'd3, 4'd5, 4'd8, 4'd10: secs = T_W'(30 * SECS_IN_DAY);
				default: secs = T_W'(31 * SECS_IN_DAY);
			endcase
			return secs;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/esc_ifs.sv
`default_nettype none

interface esc_secs_if;
	import esc_pkg::*;

	logic              valid;
	logic              ready;
	logic [SECS_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_date_if;
	import esc_pkg::*;

	logic               valid;
	logic               ready;
	logic [SEC_W-1:0]   second_of_minute;
	logic [MIN_W-1:0]   minute_of_hour;
	logic [HOUR_W-1:0]  hour_of_day;
	logic [WDAY_W-1:0]  weekday;
	logic [MDAY_W-1:0]  day_of_month;
	logic [MONTH_W-1:0] month;
	logic [YEAR_W-1:0]  year;

	modport source (output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output weekday, output day_of_month, output month,
		output year, input ready);
	modport sink   (input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input weekday, input day_of_month, input month,
		input year, output ready);
endinterface

`default_nettype wire

### hw/rtl/epoch_seconds_to_calendar_top.sv
// Channel    Dir   Payload                                          Width
// epoch      in    epoch_seconds                                    32
// calendar   out   second, minute, hour, weekday, day, month, year  6/6/5/3/5/4/12
// cfg        in    cfg_we, cfg_wdata (zone offset, signed hours)    1/5
//
// Each item takes one compare-and-subtract step per whole year, month, day, hour
// and minute of local time plus one closing step per walk, all on one shared
// 34-bit subtractor.
// epoch.ready is high only while the sequencer is idle.
// A finished beat waits in the output register; the sequencer returns to idle
// and takes the next beat while it waits. arst_n clears control and the offset to +1.
`default_nettype none

module epoch_seconds_to_calendar_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [esc_pkg::ZONE_W-1:0] cfg_wdata,
	esc_secs_if.sink                       epoch,
	esc_date_if.source                     calendar
);
	import esc_pkg::*;

	esc_state_t state_q;

	logic signed [ZONE_W-1:0] zone_q;
	logic [T_W-1:0]           t_q;
	logic [MIN_W-1:0]         min_q;
	logic [HOUR_W-1:0]        hr_q;
	logic [WDAY_W-1:0]        wd_q;
	logic [MDAY_W-1:0]        mday_q;
	logic [MONTH_W-1:0]       mon_q;
	logic [YEAR_W-1:0]        year_q;
	logic [1:0]               yr4_q;
	logic [6:0]               yr100_q;
	logic [8:0]               yr400_q;
	logic                     out_valid_q;

	logic signed [16:0]   off_ext;
	logic signed [16:0]   off_secs;
	logic signed [T_W:0]  local_t;
	logic [T_W-1:0]       t_clamp;
	logic                 accept;
	logic                 leap;
	logic [T_W-1:0]       sub_b;
	logic [DIFF_W-1:0]    diff;
	logic                 ge;
	logic [WDAY_W-1:0]    wd_inc;
	logic [3:0]           wd_sum;
	logic [WDAY_W-1:0]    wd_nxt;
	logic                 mon_done;
	logic                 out_free;

	// Apply zone offset and clamp before the epoch
	assign off_ext  = {{(17 - ZONE_W){zone_q[ZONE_W-1]}}, zone_q};
	assign off_secs = off_ext * SECS_PER_HOUR;
	assign local_t  = $signed({2'b00, epoch.epoch_seconds})
		+ {{(T_W + 1 - 17){off_secs[16]}}, off_secs};
	assign t_clamp  = local_t[T_W] ? '0 : local_t[T_W-1:0];

	assign epoch.ready = (state_q == S_IDLE);
	assign accept      = epoch.valid && epoch.ready;

	// Gregorian rule from the running year residues
	assign leap = (yr4_q == 2'd0) && ((yr100_q != 7'd0) || (yr400_q == 9'd0));

	// Select the span that the current walk strips
	always_comb begin
		case (state_q)
			S_YEAR:  sub_b = leap ? LEAP_YEAR_SECS : COMMON_YEAR_SECS;
			S_MON:   sub_b = month_secs(mon_q, leap);
			S_DAY:   sub_b = DAY_SECS;
			S_HR:    sub_b = HOUR_SECS;
			default: sub_b = MIN_SECS;
		endcase
	end

	// Shared subtract-and-compare unit
	assign diff = {1'b0, t_q} - {1'b0, sub_b};
	assign ge   = !diff[DIFF_W-1];

	// Advance the weekday by the stripped span, modulo one week
	always_comb begin
		case (state_q)
			S_YEAR:  wd_inc = leap ? 3'd2 : 3'd1;
			S_MON:   wd_inc = WDAY_W'(month_len(mon_q, leap) - 5'd28);
			default: wd_inc = 3'd1;
		endcase
	end

	assign wd_sum   = {1'b0, wd_q} + {1'b0, wd_inc};
	assign wd_nxt   = (wd_sum >= DAYS_PER_WEEK) ? WDAY_W'(wd_sum - DAYS_PER_WEEK)
		: wd_sum[WDAY_W-1:0];
	assign mon_done = (mon_q == LAST_MONTH_IDX) || !ge;
	assign out_free = !out_valid_q || calendar.ready;

	// Hold the zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (calendar.valid && calendar.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_YEAR;
					end
				end
				S_YEAR: begin
					if (!ge) begin
						state_q <= S_MON;
					end
				end
				S_MON: begin
					if (mon_done) begin
						state_q <= S_DAY;
					end
				end
				S_DAY: begin
					if (!ge) begin
						state_q <= S_HR;
					end
				end
				S_HR: begin
					if (!ge) begin
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (!ge && out_free) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: strip years, months, days, hours and minutes in turn
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q     <= t_clamp;
				year_q  <= EPOCH_YEAR;
				yr4_q   <= EPOCH_MOD4;
				yr100_q <= EPOCH_MOD100;
				yr400_q <= EPOCH_MOD400;
				wd_q    <= WEEKDAY_OF_EPOCH;
				mon_q   <= '0;
				mday_q  <= '0;
				hr_q    <= '0;
				min_q   <= '0;
			end
			S_YEAR: begin
				if (ge) begin
					t_q     <= diff[T_W-1:0];
					wd_q    <= wd_nxt;
					year_q  <= year_q + 1'b1;
					yr4_q   <= yr4_q + 1'b1;
					yr100_q <= (yr100_q == 7'd99) ? 7'd0 : yr100_q + 1'b1;
					yr400_q <= (yr400_q == 9'd399) ? 9'd0 : yr400_q + 1'b1;
				end
			end
			S_MON: begin
				if (!mon_done) begin
					t_q   <= diff[T_W-1:0];
					wd_q  <= wd_nxt;
					mon_q <= mon_q + 1'b1;
				end
			end
			S_DAY: begin
				if (ge) begin
					t_q    <= diff[T_W-1:0];
					wd_q   <= wd_nxt;
					mday_q <= mday_q + 1'b1;
				end
			end
			S_HR: begin
				if (ge) begin
					t_q  <= diff[T_W-1:0];
					hr_q <= hr_q + 1'b1;
				end
			end
			S_MIN: begin
				if (ge) begin
					t_q   <= diff[T_W-1:0];
					min_q <= min_q + 1'b1;
				end else if (out_free) begin
					calendar.second_of_minute <= t_q[SEC_W-1:0];
					calendar.minute_of_hour   <= min_q;
					calendar.hour_of_day      <= hr_q;
					calendar.weekday          <= wd_q;
					calendar.day_of_month     <= mday_q + 1'b1;
					calendar.month            <= mon_q + 1'b1;
					calendar.year             <= year_q;
				end
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	assign calendar.valid = out_valid_q;

	// Checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_YEAR))
		else $error("accepted beat did not start the year walk");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YEAR) |-> (year_q <= 12'd2106))
		else $error("year walk ran past 2106");

	a_mod4_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YEAR || state_q == S_MON) |-> (yr4_q == year_q[1:0]))
		else $error("leap residue out of step with year");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.month >= 4'd1 && calendar.month <= 4'd12
		&& calendar.day_of_month >= 5'd1))
		else $error("month or day out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.second_of_minute < 6'd60
		&& calendar.minute_of_hour < 6'd60 && calendar.hour_of_day < 5'd24
		&& calendar.weekday < 3'd7))
		else $error("time of day out of range");

endmodule

`default_nettype wire

### verif/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;

	localparam int      CLK_HALF      = 4;
	localparam int      RESET_CYCLES  = 9;
	localparam int      MAX_WAIT      = 15;
	localparam int      SETTLE_CYCLES = 300;
	localparam longint  CYCLE_LIMIT   = 2_000_000;
	localparam int      PHASES        = 12;
	localparam int      PHASE_ITEMS   = 88;

	localparam longint  SEC_PER_MIN   = 60;
	localparam longint  MIN_PER_HOUR  = 60;
	localparam longint  SEC_PER_HOUR  = 3600;
	localparam longint  HOUR_PER_DAY  = 24;
	localparam longint  SEC_PER_DAY   = 86400;
	localparam longint  DAYS_IN_WEEK  = 7;
	localparam longint  THURSDAY      = 3;
	localparam int      FIRST_YEAR    = 1970;
	localparam int      LAST_YEAR     = 2106;
	localparam longint  MAX_SECS      = 64'hFFFF_FFFF;

	localparam logic signed [esc_pkg::ZONE_W-1:0] ZONE_MIN  = esc_pkg::ZONE_W'(-16);
	localparam logic signed [esc_pkg::ZONE_W-1:0] ZONE_MAX  = esc_pkg::ZONE_W'(15);
	localparam logic signed [esc_pkg::ZONE_W-1:0] ZONE_WEST = esc_pkg::ZONE_W'(-12);
	localparam logic signed [esc_pkg::ZONE_W-1:0] ZONE_EAST = esc_pkg::ZONE_W'(14);
	localparam logic signed [esc_pkg::ZONE_W-1:0] ZONE_UTC  = esc_pkg::ZONE_W'(0);

	typedef struct packed {
		logic [esc_pkg::SEC_W-1:0]   sec;
		logic [esc_pkg::MIN_W-1:0]   min;
		logic [esc_pkg::HOUR_W-1:0]  hour;
		logic [esc_pkg::WDAY_W-1:0]  wday;
		logic [esc_pkg::MDAY_W-1:0]  mday;
		logic [esc_pkg::MONTH_W-1:0] month;
		logic [esc_pkg::YEAR_W-1:0]  year;
	} cal_date_t;

	// Calendar predictor and queue of pending conversions
	class calendar_scoreboard;
		logic signed [esc_pkg::ZONE_W-1:0] zone = esc_pkg::ZONE_RESET;
		cal_date_t pending[$];
		int unsigned mismatches = 0;
		int unsigned checked = 0;
		int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		static function bit is_leap_year(int unsigned yr);
			return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		endfunction

		static function longint year_length(int unsigned yr);
			return is_leap_year(yr) ? 366 : 365;
		endfunction

		function longint month_length(int unsigned mon, int unsigned yr);
			return month_days[mon] + ((mon == 1 && is_leap_year(yr)) ? 1 : 0);
		endfunction

		function cal_date_t convert_epoch(logic [esc_pkg::SECS_W-1:0] secs);
			longint secs_l;
			longint zone_l;
			longint t;
			longint days;
			int unsigned yr;
			int unsigned mon;
			cal_date_t d;
			secs_l = secs;
			zone_l = zone;
			// clamp before the epoch to 1970-01-01 00:00:00
			t = secs_l + zone_l * SEC_PER_HOUR;
			if (t < 0)
				t = 0;
			d.sec  = esc_pkg::SEC_W'(t % SEC_PER_MIN);
			d.min  = esc_pkg::MIN_W'((t / SEC_PER_MIN) % MIN_PER_HOUR);
			d.hour = esc_pkg::HOUR_W'((t / SEC_PER_HOUR) % HOUR_PER_DAY);
			days   = t / SEC_PER_DAY;
			d.wday = esc_pkg::WDAY_W'((days + THURSDAY) % DAYS_IN_WEEK);
			// strip whole years, then whole months
			yr = FIRST_YEAR;
			while (days >= year_length(yr)) begin
				days -= year_length(yr);
				yr++;
			end
			mon = 0;
			while (mon < 11 && days >= month_length(mon, yr)) begin
				days -= month_length(mon, yr);
				mon++;
			end
			d.mday  = esc_pkg::MDAY_W'(days + 1);
			d.month = esc_pkg::MONTH_W'(mon + 1);
			d.year  = esc_pkg::YEAR_W'(yr);
			return d;
		endfunction

		function void note_epoch(logic [esc_pkg::SECS_W-1:0] secs);
			pending.push_back(convert_epoch(secs));
		endfunction

		function void report_field(string name, int unsigned exp_v, int unsigned got_v);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			mismatches++;
		endfunction

		function void check_date(cal_date_t got);
			cal_date_t exp_d;
			if (pending.size() == 0) begin
				$display("%0t: calendar beat with no pending conversion, actual %0d-%0d-%0d",
					$time, got.year, got.month, got.mday);
				mismatches++;
				return;
			end
			exp_d = pending.pop_front();
			checked++;
			if (got.sec !== exp_d.sec)
				report_field("second_of_minute", exp_d.sec, got.sec);
			if (got.min !== exp_d.min)
				report_field("minute_of_hour", exp_d.min, got.min);
			if (got.hour !== exp_d.hour)
				report_field("hour_of_day", exp_d.hour, got.hour);
			if (got.wday !== exp_d.wday)
				report_field("weekday", exp_d.wday, got.wday);
			if (got.mday !== exp_d.mday)
				report_field("day_of_month", exp_d.mday, got.mday);
			if (got.month !== exp_d.month)
				report_field("month", exp_d.month, got.month);
			if (got.year !== exp_d.year)
				report_field("year", exp_d.year, got.year);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [esc_pkg::ZONE_W-1:0] cfg_wdata;

	esc_secs_if epoch_bus ();
	esc_date_if cal_bus ();

	calendar_scoreboard sb;
	bit steady = 1'b0;
	int unsigned items_sent = 0;
	int unsigned zone_writes = 0;
	longint cycle_count = 0;

	epoch_seconds_to_calendar_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.epoch     (epoch_bus),
		.calendar  (cal_bus)
	);

	always #CLK_HALF clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one beat after a random gap; hold valid until accepted
	task automatic send_epoch(input logic [esc_pkg::SECS_W-1:0] secs);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			epoch_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		epoch_bus.valid         <= 1'b1;
		epoch_bus.epoch_seconds <= secs;
		do @(posedge clk); while (epoch_bus.ready !== 1'b1);
		sb.note_epoch(secs);
		items_sent++;
	endtask

	// Drop valid and wait for every pending conversion to come back
	task automatic drain_all();
		epoch_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic set_zone(input logic signed [esc_pkg::ZONE_W-1:0] z);
		drain_all();
		cfg_we    <= 1'b1;
		cfg_wdata <= z;
		@(posedge clk);
		sb.zone = z;
		cfg_we <= 1'b0;
		zone_writes++;
	endtask

	// Mix of uniform values, both ends of the range and local day/year edges
	function automatic logic [esc_pkg::SECS_W-1:0] pick_epoch();
		int unsigned kind;
		int unsigned yr;
		int unsigned y;
		longint days;
		longint secs;
		longint zone_l;
		zone_l = sb.zone;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: begin
				secs = $urandom();
			end
			3: begin
				secs = $urandom_range(0, 200000);
			end
			4: begin
				secs = MAX_SECS - $urandom_range(0, 200000);
			end
			5, 6: begin
				days = $urandom_range(0, 49710);
				secs = days * SEC_PER_DAY - zone_l * SEC_PER_HOUR
					+ longint'($urandom_range(0, 4)) - 2;
			end
			default: begin
				yr = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
				days = 0;
				for (y = FIRST_YEAR; y < yr; y++)
					days += calendar_scoreboard::year_length(y);
				case ($urandom_range(0, 3))
					0: days += 0;
					1: days += 58;
					2: days += 59;
					default: days += 365;
				endcase
				secs = days * SEC_PER_DAY - zone_l * SEC_PER_HOUR
					+ longint'($urandom_range(0, 4)) - 2;
			end
		endcase
		if (secs < 0)
			secs = 0;
		if (secs > MAX_SECS)
			secs = MAX_SECS;
		return secs[esc_pkg::SECS_W-1:0];
	endfunction

	// Result side: random stall per beat, check on every handshake
	initial begin : drain_results
		int stall;
		cal_date_t got;
		cal_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				cal_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cal_bus.ready <= 1'b1;
			do @(posedge clk); while (cal_bus.valid !== 1'b1);
			got.sec   = cal_bus.second_of_minute;
			got.min   = cal_bus.minute_of_hour;
			got.hour  = cal_bus.hour_of_day;
			got.wday  = cal_bus.weekday;
			got.mday  = cal_bus.day_of_month;
			got.month = cal_bus.month;
			got.year  = cal_bus.year;
			sb.check_date(got);
		end
	end

	initial begin : stimulus
		logic [esc_pkg::SECS_W-1:0] reset_zone_set[14] = '{
			32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd82799, 32'd82800,
			32'd68169600, 32'd951782400, 32'd946684799, 32'd4102444800,
			32'd4107542399, 32'hFFFF_FFFF, 32'hAAAA_AAAA
		};
		logic [esc_pkg::SECS_W-1:0] west_set[4] = '{
			32'd0, 32'd57599, 32'd57600, 32'h5555_5555
		};
		logic [esc_pkg::SECS_W-1:0] east_set[2] = '{32'hFFFF_FFFF, 32'd0};
		logic signed [esc_pkg::ZONE_W-1:0] zone_plan[5] = '{
			ZONE_MIN, ZONE_MAX, ZONE_WEST, ZONE_EAST, ZONE_UTC
		};
		int p;
		int i;
		sb = new;
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		epoch_bus.valid         <= 1'b0;
		epoch_bus.epoch_seconds <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset offset, then both offset extremes
		foreach (reset_zone_set[k])
			send_epoch(reset_zone_set[k]);
		set_zone(ZONE_MIN);
		foreach (west_set[k])
			send_epoch(west_set[k]);
		set_zone(ZONE_MAX);
		foreach (east_set[k])
			send_epoch(east_set[k]);

		// Random phases, one offset each; every fourth phase runs without idling
		for (p = 0; p < PHASES; p++) begin
			if (p < 5)
				set_zone(zone_plan[p]);
			else
				set_zone(esc_pkg::ZONE_W'($urandom_range(0, 31)));
			steady = (p % 4 == 3);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send_epoch(pick_epoch());
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain_all();
			end
		end
		steady = 1'b0;

		drain_all();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Converted %0d epoch values across %0d zone offset writes",
			items_sent, zone_writes);
		$display("Checked %0d calendar beats, %0d field mismatches", sb.checked,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
